// File: hw/rtl/rgb_to_hsv_converter_assert.svh
// ----------------------------------------------------------------------------
// RGB to HSV converter assertion macros
// Property wrappers shared by the checker, clocked on clk_i and quiet
// while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSV_CONVERTER_ASSERT_SVH
`define RGB_TO_HSV_CONVERTER_ASSERT_SVH

// Same-cycle implication.
`define R2H_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("r2h assertion failed");

// Next-cycle implication.
`define R2H_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("r2h assertion failed");

`endif

// File: hw/rtl/r2h_pkg.sv
// ----------------------------------------------------------------------------
// RGB to HSV converter package
// Word types, divider lane types and hue constants shared by all modules.
// ----------------------------------------------------------------------------
package r2h_pkg;

  // One quotient bit is resolved per cell.
  localparam int unsigned NumCells = 16;

  localparam logic [14:0] HueFullTurn  = 15'd23040;
  localparam logic [14:0] HueBaseGreen = 15'd7680;
  localparam logic [14:0] HueBaseBlue  = 15'd15360;
  localparam logic [14:0] HueBaseRed   = 15'd0;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [14:0] hue;
    logic [15:0] saturation;
    logic [7:0]  brightness;
  } hsv_t;

  // Restoring divider lane: partial remainder, dividend bits still to be
  // shifted in at the top with quotient bits collected at the bottom, and
  // the divisor.
  typedef struct packed {
    logic [7:0]  rem;
    logic [15:0] bits;
    logic [7:0]  dvs;
  } div_lane_t;

  typedef struct packed {
    logic [7:0]  brightness;
    logic [14:0] hue_base;
    logic        hue_neg;
  } side_t;

  typedef struct packed {
    logic      valid;
    side_t     side;
    div_lane_t sat;
    div_lane_t hue;
  } cell_word_t;

endpackage

// File: hw/rtl/r2h_front.sv
// ----------------------------------------------------------------------------
// RGB to HSV front stage
// Finds max and min, picks the hue sector and loads both divider lanes.
// ----------------------------------------------------------------------------
module r2h_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  r2h_pkg::pixel_t    pixel_i,
  output r2h_pkg::cell_word_t word_o
);

  logic [7:0]  r, g, b;
  logic        red_max, green_max;
  logic [7:0]  hi, lo, d;
  logic [8:0]  num;
  logic        neg;
  logic [8:0]  num_abs;
  logic [7:0]  mag;
  logic [19:0] hue_n;
  logic [23:0] sat_n;
  logic [14:0] base;

  logic               valid_q;
  r2h_pkg::side_t     side_q;
  r2h_pkg::div_lane_t sat_q, hue_q;
  r2h_pkg::side_t     side_d;
  r2h_pkg::div_lane_t sat_d, hue_d;

  assign r = pixel_i.red;
  assign g = pixel_i.green;
  assign b = pixel_i.blue;

  // Ties go to red first, then green.
  assign red_max   = (r >= g) && (r >= b);
  assign green_max = !red_max && (g >= b);

  always_comb begin
    if (red_max) begin
      hi  = r;
      num = {1'b0, g} - {1'b0, b};
    end else if (green_max) begin
      hi  = g;
      num = {1'b0, b} - {1'b0, r};
    end else begin
      hi  = b;
      num = {1'b0, r} - {1'b0, g};
    end
  end

  assign lo = (r <= g) ? ((r <= b) ? r : b) : ((g <= b) ? g : b);
  assign d  = hi - lo;

  assign neg     = num[8];
  assign num_abs = neg ? (9'd0 - num) : num;
  assign mag     = num_abs[7:0];

  // A negative hue in the red sector wraps by a full turn.
  always_comb begin
    if (red_max) begin
      base = neg ? r2h_pkg::HueFullTurn : r2h_pkg::HueBaseRed;
    end else if (green_max) begin
      base = r2h_pkg::HueBaseGreen;
    end else begin
      base = r2h_pkg::HueBaseBlue;
    end
  end

  // 3840 * |num| and 65535 * d, built from shifts.
  assign hue_n = {mag, 12'd0} - {4'd0, mag, 8'd0};
  assign sat_n = {d, 16'd0} - {16'd0, d};

  // The quotient always fits in 16 bits, so the top dividend byte starts
  // out below the divisor. A zero divisor only occurs with a zero dividend
  // and is replaced by one so that the quotient comes out zero.
  always_comb begin
    side_d.brightness = hi;
    side_d.hue_base   = base;
    side_d.hue_neg    = neg;
    sat_d.rem         = sat_n[23:16];
    sat_d.bits        = sat_n[15:0];
    sat_d.dvs         = (hi == 8'd0) ? 8'd1 : hi;
    hue_d.rem         = 8'd0;
    hue_d.bits        = hue_n[15:0];
    hue_d.dvs         = (d == 8'd0) ? 8'd1 : d;
    hue_d.rem[3:0]    = hue_n[19:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_d;
      sat_q  <= sat_d;
      hue_q  <= hue_d;
    end
  end

  assign word_o.valid = valid_q;
  assign word_o.side  = side_q;
  assign word_o.sat   = sat_q;
  assign word_o.hue   = hue_q;

endmodule

// File: hw/rtl/r2h_div_cell.sv
// ----------------------------------------------------------------------------
// RGB to HSV divider cell
// One restoring division step on the saturation and hue lanes, registered.
// ----------------------------------------------------------------------------
module r2h_div_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  r2h_pkg::cell_word_t word_i,
  output r2h_pkg::cell_word_t word_o
);

  function automatic r2h_pkg::div_lane_t div_step(input r2h_pkg::div_lane_t lane);
    r2h_pkg::div_lane_t res;
    logic [8:0] trial;
    logic [8:0] diff;
    logic       ge;
    trial    = {lane.rem, lane.bits[15]};
    diff     = trial - {1'b0, lane.dvs};
    ge       = (trial >= {1'b0, lane.dvs});
    // The remainder stays below the divisor, so one subtract is enough.
    res.rem  = ge ? diff[7:0] : trial[7:0];
    res.bits = {lane.bits[14:0], ge};
    res.dvs  = lane.dvs;
    return res;
  endfunction

  logic               valid_q;
  r2h_pkg::side_t     side_q;
  r2h_pkg::div_lane_t sat_q, hue_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= word_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= word_i.side;
      sat_q  <= div_step(word_i.sat);
      hue_q  <= div_step(word_i.hue);
    end
  end

  assign word_o.valid = valid_q;
  assign word_o.side  = side_q;
  assign word_o.sat   = sat_q;
  assign word_o.hue   = hue_q;

endmodule

// File: hw/rtl/r2h_out_buf.sv
// ----------------------------------------------------------------------------
// RGB to HSV output buffer
// Applies the hue sector offset and sign, then holds results in an output
// register backed by a skid register.
// ----------------------------------------------------------------------------
module r2h_out_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  r2h_pkg::cell_word_t word_i,
  output logic                en_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output r2h_pkg::hsv_t       out_data_o
);

  logic [14:0]   quo;
  logic [14:0]   carry;
  logic          incoming;
  r2h_pkg::hsv_t result;

  logic          out_valid_q, skid_valid_q;
  r2h_pkg::hsv_t out_q, skid_q;

  // Negative differences need the floor, so a nonzero remainder rounds
  // the quotient away from zero.
  assign quo   = {3'd0, word_i.hue.bits[11:0]};
  assign carry = {14'd0, (word_i.hue.rem != 8'd0)};

  always_comb begin
    result.brightness = word_i.side.brightness;
    result.saturation = word_i.sat.bits;
    if (word_i.side.hue_neg) begin
      result.hue = word_i.side.hue_base - quo - carry;
    end else begin
      result.hue = word_i.side.hue_base + quo;
    end
  end

  // The chain moves whenever the skid register is free.
  assign en_o     = !skid_valid_q;
  assign incoming = en_o && word_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (!out_valid_q || out_ready_i) begin
        out_valid_q <= skid_valid_q || incoming;
      end
      if (skid_valid_q) begin
        if (out_ready_i) begin
          skid_valid_q <= 1'b0;
        end
      end else if (incoming && out_valid_q && !out_ready_i) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_ready_i) begin
      out_q <= skid_valid_q ? skid_q : result;
    end
    if (!skid_valid_q && incoming && out_valid_q && !out_ready_i) begin
      skid_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: hw/rtl/rgb_to_hsv_converter.sv
// An accepted pixel passes the front stage register, the divider cells and the output register in turn.
// Throughput: one pixel per cycle while the skid register is free, through the 16-cell divider chain that
// resolves one quotient bit of saturation and hue per cell.
// A waiting output word is held in an output register plus a skid register.
// Reset clears only valid flags; data registers are not reset.
// ----------------------------------------------------------------------------
// RGB to HSV converter
// Front stage, divider cell chain and output buffer.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  r2h_pkg::pixel_t in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output r2h_pkg::hsv_t   out_data_o
);

  logic                en;
  r2h_pkg::cell_word_t chain [r2h_pkg::NumCells+1];

  assign in_ready_o = en;

  r2h_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .pixel_i (in_data_i),
    .word_o  (chain[0])
  );

  for (genvar k = 0; k < r2h_pkg::NumCells; k++) begin : g_cell
    r2h_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .word_i (chain[k]),
      .word_o (chain[k+1])
    );
  end

  r2h_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .word_i      (chain[r2h_pkg::NumCells]),
    .en_o        (en),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: hw/rtl/r2h_checker.sv
// ----------------------------------------------------------------------------
// RGB to HSV converter checker
// Port-level properties of the converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "rgb_to_hsv_converter_assert.svh"

module r2h_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_o,
  input r2h_pkg::pixel_t in_data_i,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input r2h_pkg::hsv_t   out_data_o
);

  // A stalled word stays put.
  `R2H_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))

  // Hue stays below a full turn.
  `R2H_ASSERT_NOW(a_hue_range, out_valid_o, out_data_o.hue < r2h_pkg::HueFullTurn)

  // A black pixel has no saturation and no hue.
  `R2H_ASSERT_NOW(a_black, out_valid_o && out_data_o.brightness == 8'd0, out_data_o.saturation == 16'd0 && out_data_o.hue == 15'd0)

  // With nothing waiting at the output, input is never blocked.
  `R2H_ASSERT_NOW(a_ready_free, !out_valid_o, in_ready_o)

endmodule

bind rgb_to_hsv_converter r2h_checker u_checker (.*);
